@@ hw/rtl/acc6_pkg.sv @@
// ----------------------------------------------------------------------------
// acc6_pkg
// Shared types and constants for the six-position accelerometer bias
// calibration block.
// ----------------------------------------------------------------------------
package acc6_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 17;
    localparam int SETTLE_W   = 10;
    localparam int THR_W      = 15;
    localparam int NUM_ORIENT = 6;
    localparam int ORIENT_W   = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 15;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 64;
    localparam int NUM_STAGES = 5;

    localparam int DEF_CAPTURE_SAMPLES = 100;

    localparam logic [SETTLE_W-1:0]   SETTLE_RST  = 10'd400;
    localparam logic [THR_W-1:0]      THR_RST     = 15'd231;
    localparam logic [SETTLE_W-1:0]   SETTLE_MAX  = {SETTLE_W{1'b1}};
    localparam logic [NUM_ORIENT-1:0] ORIENT_ALL  = {NUM_ORIENT{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SCAN    = 2'd1,
        PH_SETTLE  = 2'd2,
        PH_CAPTURE = 2'd3
    } phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SETTLE    = 1'b0,
        CFG_THRESHOLD = 1'b1
    } cfg_reg_t;

    // Accumulator commands from the control stage to each axis lane
    typedef struct packed {
        logic                clr;
        logic                acc_en;
        logic                store;
        logic [ORIENT_W-1:0] idx;
    } lane_ctl_t;

    // Per-item status carried down the pipeline
    typedef struct packed {
        logic                  start;
        logic                  cal;
        logic                  load;
        phase_t                phase;
        logic [NUM_ORIENT-1:0] mask;
    } item_stat_t;

    // Stage load enables and last-stage flags handed to the lanes
    typedef struct packed {
        logic [NUM_STAGES:1] ld;
        logic                ldo;
        logic                load;
        logic                cal;
    } pipe_ctl_t;

endpackage

@@ hw/rtl/accel_six_position_bias_calibration.sv @@
// ----------------------------------------------------------------------------
// accel_six_position_bias_calibration
// Six-position accelerometer bias calibration with per-axis bias removal.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output side does not stall,
// and returns one result per item through the output register. The control
// stage updates the calibration sequence as an item enters; three axis lanes
// then run a five-stage pipeline (input sample, pair sums, four-orientation
// total, rounding, reciprocal multiply) that produces the rounded bias in
// time for the very item that completes calibration. Samples are in counts of
// 1/256 g; results carry the raw sample until calibrated, the sample minus
// bias afterwards, and zeros in the axis fields for a start item.
module accel_six_position_bias_calibration #(
    parameter int CAPTURE_SAMPLES = acc6_pkg::DEF_CAPTURE_SAMPLES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [acc6_pkg::S_DATA_W-1:0]      s_tdata,   // x_raw, y_raw, z_raw
    input  logic [0:0]                         s_tuser,   // action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // x_out, y_out, z_out, is_calibrated, phase, captured_mask, zero pad
    output logic [acc6_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [acc6_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [acc6_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import acc6_pkg::*;

    localparam int CAL_BIT   = 3 * OUT_W;
    localparam int PHASE_LSB = CAL_BIT + 1;
    localparam int MASK_LSB  = PHASE_LSB + 2;

    logic [SETTLE_W-1:0] settle_reg;
    logic [THR_W-1:0]    thr_reg;

    logic [NUM_STAGES:1]   v_reg;
    logic [NUM_STAGES:1]   v_in;
    item_stat_t            st_reg [1:NUM_STAGES];
    logic [NUM_STAGES+1:1] rdy;
    logic                  accept;
    logic                  mv_reg;
    logic [M_DATA_W-1:0]   out_reg, out_next;

    lane_ctl_t             lane_ctl;
    item_stat_t            stat;
    pipe_ctl_t             pipe_ctl;
    logic signed [OUT_W-1:0] corr [3];

    logic signed [SAMPLE_W-1:0] x_raw, y_raw, z_raw;

    assign x_raw = s_tdata[0 +: SAMPLE_W];
    assign y_raw = s_tdata[SAMPLE_W +: SAMPLE_W];
    assign z_raw = s_tdata[2*SAMPLE_W +: SAMPLE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_RST;
            thr_reg    <= THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_SETTLE:    settle_reg <= cfg_wdata[SETTLE_W-1:0];
                CFG_THRESHOLD: thr_reg    <= cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Ready ripples back from the output register; a stage loads when empty or when the next stage takes its item
    always_comb begin
        rdy[NUM_STAGES+1] = !mv_reg || m_tready;
        for (int i = NUM_STAGES; i >= 1; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_in = {v_reg[NUM_STAGES-1:1], s_tvalid};
    end

    assign s_tready = rdy[1];
    assign accept   = s_tvalid && rdy[1];

    acc6_ctrl #(
        .CAPTURE_SAMPLES (CAPTURE_SAMPLES)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept_i         (accept),
        .action_i         (s_tuser[0]),
        .x_i              (x_raw),
        .y_i              (y_raw),
        .z_i              (z_raw),
        .settle_samples_i (settle_reg),
        .threshold_i      (thr_reg),
        .lane_ctl_o       (lane_ctl),
        .stat_o           (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 1; i <= NUM_STAGES; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            st_reg[1] <= stat;
        end
        for (int i = 2; i <= NUM_STAGES; i++) begin
            if (rdy[i]) begin
                st_reg[i] <= st_reg[i-1];
            end
        end
    end

    always_comb begin
        pipe_ctl.ld   = rdy[NUM_STAGES:1];
        pipe_ctl.ldo  = rdy[NUM_STAGES+1] && v_reg[NUM_STAGES];
        pipe_ctl.load = st_reg[NUM_STAGES].load;
        pipe_ctl.cal  = st_reg[NUM_STAGES].cal;
    end

    acc6_lane #(
        .CAPTURE_SAMPLES (CAPTURE_SAMPLES)
    ) u_lane_x (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pair_sel_i (1'b0),
        .sample_i   (x_raw),
        .lane_ctl_i (lane_ctl),
        .pipe_i     (pipe_ctl),
        .corr_o     (corr[0])
    );

    acc6_lane #(
        .CAPTURE_SAMPLES (CAPTURE_SAMPLES)
    ) u_lane_y (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pair_sel_i (1'b1),
        .sample_i   (y_raw),
        .lane_ctl_i (lane_ctl),
        .pipe_i     (pipe_ctl),
        .corr_o     (corr[1])
    );

    acc6_lane #(
        .CAPTURE_SAMPLES (CAPTURE_SAMPLES)
    ) u_lane_z (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pair_sel_i (1'b0),
        .sample_i   (z_raw),
        .lane_ctl_i (lane_ctl),
        .pipe_i     (pipe_ctl),
        .corr_o     (corr[2])
    );

    // Merge the lane results with the item status
    always_comb begin
        out_next = '0;
        if (!st_reg[NUM_STAGES].start) begin
            out_next[0 +: OUT_W]       = corr[0];
            out_next[OUT_W +: OUT_W]   = corr[1];
            out_next[2*OUT_W +: OUT_W] = corr[2];
        end
        out_next[CAL_BIT]                 = st_reg[NUM_STAGES].cal;
        out_next[PHASE_LSB +: 2]          = st_reg[NUM_STAGES].phase;
        out_next[MASK_LSB +: NUM_ORIENT]  = st_reg[NUM_STAGES].mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (rdy[NUM_STAGES+1]) begin
            mv_reg <= v_reg[NUM_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NUM_STAGES+1]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_all_captured_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[MASK_LSB +: NUM_ORIENT] == ORIENT_ALL |-> m_tdata[CAL_BIT])
        else $error("all orientations captured but not calibrated");

    a_cal_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[CAL_BIT] |-> m_tdata[PHASE_LSB +: 2] == PH_IDLE)
        else $error("calibrated result outside idle phase");

    a_uncal_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[CAL_BIT] && m_tdata[PHASE_LSB +: 2] == PH_IDLE
            |-> m_tdata[MASK_LSB +: NUM_ORIENT] == '0)
        else $error("idle and uncalibrated with captured orientations");
`endif

endmodule

@@ hw/rtl/acc6_ctrl.sv @@
// ----------------------------------------------------------------------------
// acc6_ctrl
// Calibration sequencer: orientation detection, settle and capture counting,
// captured flags and the calibrated mark.
// ----------------------------------------------------------------------------
module acc6_ctrl #(
    parameter int CAPTURE_SAMPLES = acc6_pkg::DEF_CAPTURE_SAMPLES
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   accept_i,
    input  logic                                   action_i,
    input  logic signed [acc6_pkg::SAMPLE_W-1:0]   x_i,
    input  logic signed [acc6_pkg::SAMPLE_W-1:0]   y_i,
    input  logic signed [acc6_pkg::SAMPLE_W-1:0]   z_i,
    input  logic        [acc6_pkg::SETTLE_W-1:0]   settle_samples_i,
    input  logic        [acc6_pkg::THR_W-1:0]      threshold_i,
    output acc6_pkg::lane_ctl_t                    lane_ctl_o,
    output acc6_pkg::item_stat_t                   stat_o
);
    import acc6_pkg::*;

    localparam int SAMP_W = $clog2(CAPTURE_SAMPLES + 1);
    localparam logic [SAMP_W-1:0] SAMP_END = SAMP_W'(CAPTURE_SAMPLES);

    phase_t                phase_reg, phase_next;
    logic [NUM_ORIENT-1:0] flags_reg, flags_next;
    logic                  cal_reg, cal_next;
    logic [ORIENT_W-1:0]   cur_reg, cur_next;
    logic [SETTLE_W-1:0]   settle_reg, settle_next;
    logic [SAMP_W-1:0]     samp_reg, samp_next;

    logic signed [SAMPLE_W:0] thr_pos, thr_neg;
    logic [NUM_ORIENT-1:0]    pass;
    logic [NUM_ORIENT-1:0]    flags_upd;
    logic [NUM_ORIENT-1:0]    above;
    logic [NUM_ORIENT-1:0]    cand_scan, cand_end;
    logic [ORIENT_W-1:0]      idx_scan, idx_end;
    logic [SETTLE_W-1:0]      settle_inc;
    logic [SAMP_W-1:0]        samp_inc;
    logic                     load;

    // Axis tests: even orientations point up, odd ones point down
    always_comb begin
        thr_pos = $signed({2'b00, threshold_i});
        thr_neg = -thr_pos;
        pass[0] = $signed({z_i[SAMPLE_W-1], z_i}) >= thr_pos;
        pass[1] = $signed({z_i[SAMPLE_W-1], z_i}) <= thr_neg;
        pass[2] = $signed({y_i[SAMPLE_W-1], y_i}) >= thr_pos;
        pass[3] = $signed({y_i[SAMPLE_W-1], y_i}) <= thr_neg;
        pass[4] = $signed({x_i[SAMPLE_W-1], x_i}) >= thr_pos;
        pass[5] = $signed({x_i[SAMPLE_W-1], x_i}) <= thr_neg;
    end

    always_comb begin
        flags_upd = flags_reg;
        flags_upd[cur_reg] = 1'b1;
        for (int i = 0; i < NUM_ORIENT; i++) begin
            above[i] = (ORIENT_W'(i) > cur_reg);
        end
        cand_scan = pass & ~flags_reg;
        cand_end  = pass & ~flags_upd & above;
        // lowest candidate wins
        idx_scan = '0;
        idx_end  = '0;
        for (int i = NUM_ORIENT - 1; i >= 0; i--) begin
            if (cand_scan[i]) begin
                idx_scan = ORIENT_W'(i);
            end
            if (cand_end[i]) begin
                idx_end = ORIENT_W'(i);
            end
        end
        settle_inc = (settle_reg < SETTLE_MAX) ? settle_reg + 1'b1 : settle_reg;
        samp_inc   = samp_reg + 1'b1;
    end

    always_comb begin
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        cal_next    = cal_reg;
        cur_next    = cur_reg;
        settle_next = settle_reg;
        samp_next   = samp_reg;
        lane_ctl_o  = '0;
        load        = 1'b0;
        if (accept_i) begin
            if (action_i) begin
                phase_next     = PH_SCAN;
                flags_next     = '0;
                cal_next       = 1'b0;
                cur_next       = '0;
                settle_next    = '0;
                samp_next      = '0;
                lane_ctl_o.clr = 1'b1;
            end else begin
                case (phase_reg)
                    PH_SCAN: begin
                        if (|cand_scan) begin
                            cur_next       = idx_scan;
                            settle_next    = '0;
                            samp_next      = '0;
                            lane_ctl_o.clr = 1'b1;
                            phase_next     = (settle_samples_i == '0) ? PH_CAPTURE : PH_SETTLE;
                        end
                    end
                    PH_SETTLE: begin
                        settle_next = settle_inc;
                        if (settle_inc >= settle_samples_i) begin
                            phase_next = PH_CAPTURE;
                        end
                    end
                    PH_CAPTURE: begin
                        lane_ctl_o.acc_en = 1'b1;
                        samp_next         = samp_inc;
                        if (samp_inc >= SAMP_END) begin
                            lane_ctl_o.store = 1'b1;
                            lane_ctl_o.idx   = cur_reg;
                            flags_next       = flags_upd;
                            if (flags_upd == ORIENT_ALL) begin
                                cal_next   = 1'b1;
                                load       = 1'b1;
                                phase_next = PH_IDLE;
                                samp_next  = '0;
                            end else if (|cand_end) begin
                                // recheck higher orientations on this last sample
                                cur_next       = idx_end;
                                settle_next    = '0;
                                samp_next      = '0;
                                lane_ctl_o.clr = 1'b1;
                                phase_next     = (settle_samples_i == '0) ? PH_CAPTURE
                                                                          : PH_SETTLE;
                            end else begin
                                phase_next = PH_SCAN;
                                samp_next  = '0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        stat_o.start = action_i;
        stat_o.cal   = cal_next;
        stat_o.load  = load;
        stat_o.phase = phase_next;
        stat_o.mask  = flags_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            flags_reg  <= '0;
            cal_reg    <= 1'b0;
            cur_reg    <= '0;
            settle_reg <= '0;
            samp_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            flags_reg  <= flags_next;
            cal_reg    <= cal_next;
            cur_reg    <= cur_next;
            settle_reg <= settle_next;
            samp_reg   <= samp_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |->
            (flags_reg == '0 && !cal_reg) || (flags_reg == ORIENT_ALL && cal_reg))
        else $error("idle with partial calibration state");

    a_samp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CAPTURE |-> samp_reg < SAMP_END)
        else $error("capture count ran past its end");

    a_cur_uncaptured: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SETTLE || phase_reg == PH_CAPTURE) |-> !flags_reg[cur_reg])
        else $error("capturing an orientation already captured");
`endif

endmodule

@@ hw/rtl/acc6_lane.sv @@
// ----------------------------------------------------------------------------
// acc6_lane
// One axis lane: capture accumulator, per-orientation sums, pipelined
// rounded bias division and bias removal.
// ----------------------------------------------------------------------------
module acc6_lane #(
    parameter int CAPTURE_SAMPLES = acc6_pkg::DEF_CAPTURE_SAMPLES
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 pair_sel_i,   // 1: orientations 2/3, 0: 4/5
    input  logic signed [acc6_pkg::SAMPLE_W-1:0] sample_i,
    input  acc6_pkg::lane_ctl_t                  lane_ctl_i,
    input  acc6_pkg::pipe_ctl_t                  pipe_i,
    output logic signed [acc6_pkg::OUT_W-1:0]    corr_o
);
    import acc6_pkg::*;

    localparam int ACC_W  = 17 + $clog2(CAPTURE_SAMPLES);
    localparam int PAIR_W = ACC_W + 1;
    localparam int TOT_W  = ACC_W + 2;
    localparam int NW     = TOT_W;
    localparam int MW     = NW + 1;
    localparam int PW     = NW + MW;
    localparam int Q_W    = SAMPLE_W + 1;
    localparam int DEN    = 4 * CAPTURE_SAMPLES;
    localparam int DEN_L  = $clog2(DEN);
    localparam int SHIFT  = NW + DEN_L;
    localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + DEN - 1) / DEN;
    localparam logic [MW-1:0] RECIP = RECIP_L[MW-1:0];
    localparam logic signed [TOT_W-1:0] HALF = TOT_W'(DEN / 2);

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    sums_reg [NUM_ORIENT];
    logic signed [SAMPLE_W-1:0] s_reg [1:NUM_STAGES];
    logic signed [PAIR_W-1:0]   pa_reg, pb_reg;
    logic signed [PAIR_W-1:0]   pa_next, pb_next;
    logic signed [TOT_W-1:0]    tot_reg;
    logic signed [TOT_W-1:0]    mag_next;
    logic [NW-1:0]              mag_reg;
    logic                       neg4_reg, neg5_reg;
    logic [PW-1:0]              prod_reg;
    logic signed [SAMPLE_W-1:0] bias_reg, bias_next;
    logic [Q_W-1:0]             q, q_neg;
    logic signed [OUT_W:0]      s5x, qx, bx, diff;

    assign acc_sum = acc_reg + ACC_W'(sample_i);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (lane_ctl_i.clr) begin
            acc_reg <= '0;
        end else if (lane_ctl_i.acc_en) begin
            acc_reg <= acc_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (lane_ctl_i.store) begin
            sums_reg[lane_ctl_i.idx] <= acc_sum;
        end
    end

    always_comb begin
        pa_next = PAIR_W'(sums_reg[0]) + PAIR_W'(sums_reg[1]);
        pb_next = pair_sel_i ? PAIR_W'(sums_reg[2]) + PAIR_W'(sums_reg[3])
                             : PAIR_W'(sums_reg[4]) + PAIR_W'(sums_reg[5]);
        // round half away from zero: bias the magnitude by half the divisor
        mag_next = tot_reg[TOT_W-1] ? HALF - tot_reg : tot_reg + HALF;
    end

    always_ff @(posedge aclk) begin
        if (pipe_i.ld[1]) begin
            s_reg[1] <= sample_i;
        end
        if (pipe_i.ld[2]) begin
            s_reg[2] <= s_reg[1];
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
        end
        if (pipe_i.ld[3]) begin
            s_reg[3] <= s_reg[2];
            tot_reg  <= TOT_W'(pa_reg) + TOT_W'(pb_reg);
        end
        if (pipe_i.ld[4]) begin
            s_reg[4] <= s_reg[3];
            neg4_reg <= tot_reg[TOT_W-1];
            mag_reg  <= mag_next[NW-1:0];
        end
        if (pipe_i.ld[5]) begin
            s_reg[5] <= s_reg[4];
            neg5_reg <= neg4_reg;
            prod_reg <= PW'(mag_reg) * PW'(RECIP);
        end
    end

    always_comb begin
        q     = prod_reg[SHIFT +: Q_W];
        q_neg = ~q + 1'b1;
        bias_next = neg5_reg ? q_neg[SAMPLE_W-1:0] : q[SAMPLE_W-1:0];
        s5x = (OUT_W + 1)'(s_reg[5]);
        qx  = $signed({1'b0, q});
        bx  = (OUT_W + 1)'(bias_reg);
        if (!pipe_i.cal) begin
            diff = s5x;
        end else if (pipe_i.load) begin
            // new bias applies to the item that completes calibration
            diff = neg5_reg ? s5x + qx : s5x - qx;
        end else begin
            diff = s5x - bx;
        end
        corr_o = diff[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= '0;
        end else if (pipe_i.ldo && pipe_i.load) begin
            bias_reg <= bias_next;
        end
    end

endmodule
